[hdl/mthi_pkg.sv]
// Package for the map tile hierarchy index block.
// Holds the per-layer span tables, the result struct and shared constants.
// No dependencies.
package mthi_pkg;

  localparam int CoordWidth  = 26;
  localparam int ZoomWidth   = 4;
  localparam int SetWidth    = 16;
  localparam int SubWidth    = 6;
  localparam int TableLayers = 9;
  localparam int Levels      = 9;

  typedef struct packed {
    logic [4:0] cell_shift;
    logic [4:0] set_shift;
    logic [3:0] set_cols_log;
    logic [1:0] blk_log;
    logic [1:0] par_log;
    logic [1:0] unit_log;
  } layer_params_t;

  typedef struct packed {
    logic [SetWidth-1:0] blockset_index;
    logic [SubWidth-1:0] block_index;
    logic [SubWidth-1:0] parcel_index;
    logic [SubWidth-1:0] unit_index;
    logic                range_error;
  } result_t;

  // Spans per layer, all as log2 values.
  function automatic layer_params_t layer_params(input logic [ZoomWidth-1:0] zoom);
    layer_params_t p;
    p = '0;
    case (zoom)
      4'd0:    p = '{5'd9,  5'd18, 4'd8, 2'd3, 2'd3, 2'd3};
      4'd1:    p = '{5'd11, 5'd20, 4'd6, 2'd3, 2'd3, 2'd3};
      4'd2:    p = '{5'd12, 5'd21, 4'd5, 2'd3, 2'd3, 2'd3};
      4'd3:    p = '{5'd16, 5'd25, 4'd1, 2'd3, 2'd3, 2'd3};
      4'd4:    p = '{5'd16, 5'd25, 4'd1, 2'd3, 2'd3, 2'd3};
      4'd5:    p = '{5'd18, 5'd25, 4'd1, 2'd1, 2'd3, 2'd3};
      4'd6:    p = '{5'd20, 5'd25, 4'd1, 2'd0, 2'd2, 2'd3};
      4'd7:    p = '{5'd22, 5'd25, 4'd1, 2'd0, 2'd0, 2'd3};
      4'd8:    p = '{5'd23, 5'd25, 4'd1, 2'd0, 2'd0, 2'd2};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

[hdl/mthi_index_calc.sv]
// Combinational index split for one coordinate pair and zoom level.
// Depends on mthi_pkg for the layer tables and the result struct.
module mthi_index_calc (
  input  logic signed [mthi_pkg::CoordWidth-1:0] coord_x,
  input  logic signed [mthi_pkg::CoordWidth-1:0] coord_y,
  input  logic        [mthi_pkg::ZoomWidth-1:0]  zoom_level,
  output mthi_pkg::result_t                      result
);

  // Extract up to three bits at a variable offset; width 0 gives 0.
  function automatic logic [2:0] field_of(input logic [mthi_pkg::CoordWidth-1:0] v,
                                          input logic [3:0] sh,
                                          input logic [1:0] bits);
    logic [mthi_pkg::CoordWidth-1:0] t;
    logic [2:0] mask;
    t    = v >> sh;
    mask = ~(3'b111 << bits);
    return t[2:0] & mask;
  endfunction

  function automatic logic [mthi_pkg::SubWidth-1:0] combine(input logic [2:0] col,
                                                             input logic [2:0] row,
                                                             input logic [1:0] bits);
    logic [mthi_pkg::SubWidth-1:0] c6;
    logic [mthi_pkg::SubWidth-1:0] r6;
    c6 = {3'b000, col};
    r6 = {3'b000, row};
    return c6 + (r6 << bits);
  endfunction

  localparam logic [4:0] LevelLimit = 5'(mthi_pkg::Levels);
  localparam logic [4:0] TableLimit = 5'(mthi_pkg::TableLayers);

  mthi_pkg::layer_params_t         p;
  logic [mthi_pkg::CoordWidth-1:0] wx;
  logic [mthi_pkg::CoordWidth-1:0] wy;
  logic [mthi_pkg::CoordWidth-1:0] cx;
  logic [mthi_pkg::CoordWidth-1:0] cy;
  logic [mthi_pkg::CoordWidth-1:0] sx;
  logic [mthi_pkg::CoordWidth-1:0] sy;
  logic [mthi_pkg::CoordWidth-1:0] set_sum;
  logic [3:0]                      par_off;
  logic [3:0]                      blk_off;
  logic                            bad_level;

  always_comb begin
    p         = mthi_pkg::layer_params(zoom_level);
    // Move into the unsigned world: adding 2^25 flips the sign bit.
    wx        = {~coord_x[mthi_pkg::CoordWidth-1], coord_x[mthi_pkg::CoordWidth-2:0]};
    wy        = {~coord_y[mthi_pkg::CoordWidth-1], coord_y[mthi_pkg::CoordWidth-2:0]};
    cx        = wx >> p.cell_shift;
    cy        = wy >> p.cell_shift;
    sx        = wx >> p.set_shift;
    sy        = wy >> p.set_shift;
    set_sum   = sx + (sy << p.set_cols_log);
    par_off   = {2'b00, p.unit_log};
    blk_off   = {2'b00, p.unit_log} + {2'b00, p.par_log};
    bad_level = ({1'b0, zoom_level} >= LevelLimit) || ({1'b0, zoom_level} >= TableLimit);

    result = '0;
    if (bad_level) begin
      result.range_error = 1'b1;
    end else begin
      result.blockset_index = set_sum[mthi_pkg::SetWidth-1:0];
      result.block_index    = combine(field_of(cx, blk_off, p.blk_log),
                                      field_of(cy, blk_off, p.blk_log), p.blk_log);
      result.parcel_index   = combine(field_of(cx, par_off, p.par_log),
                                      field_of(cy, par_off, p.par_log), p.par_log);
      result.unit_index     = combine(field_of(cx, 4'd0, p.unit_log),
                                      field_of(cy, 4'd0, p.unit_log), p.unit_log);
    end
  end

endmodule

[hdl/map_tile_hierarchy_index_core.sv]
// Top level of the map tile hierarchy index block: input register, index
// split, result register. Depends on mthi_pkg and mthi_index_calc.
// Usage:
//   Input channel (in_valid / in_ready) carries one item: coord_x, coord_y
//   (signed 26-bit world coordinates) and zoom_level (layer 0 to 8).
//   Output channel (out_valid / out_ready) carries one result item per input:
//   blockset_index, block_index, parcel_index, unit_index and range_error.
//   A zoom_level above 8 sets range_error and zeroes all four indices.
// Flow:
//   An accepted item sits in the input register; the index split then loads
//   the result register, which raises out_valid, unless out_ready stalls it.
//   Throughput is one item per cycle while out_ready stays high; the split is
//   only barrel shifts, masks and short adds, so nothing in the path iterates.
// Stall:
//   When out_ready is low with a result waiting, the result register holds,
//   the input register still takes one more item, and in_ready drops only
//   once both stages are full. Ready flows back through each stage in the
//   same cycle, so no bubble appears when the receiver resumes.
// Reset:
//   rst (synchronous, active high) empties both stages; no other state.
module map_tile_hierarchy_index_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mthi_pkg::CoordWidth-1:0] coord_x,
  input  logic signed [mthi_pkg::CoordWidth-1:0] coord_y,
  input  logic        [mthi_pkg::ZoomWidth-1:0]  zoom_level,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [mthi_pkg::SetWidth-1:0]   blockset_index,
  output logic        [mthi_pkg::SubWidth-1:0]   block_index,
  output logic        [mthi_pkg::SubWidth-1:0]   parcel_index,
  output logic        [mthi_pkg::SubWidth-1:0]   unit_index,
  output logic                                   range_error
);

  // Input stage registers.
  logic                                   s1_valid;
  logic signed [mthi_pkg::CoordWidth-1:0] s1_x;
  logic signed [mthi_pkg::CoordWidth-1:0] s1_y;
  logic        [mthi_pkg::ZoomWidth-1:0]  s1_zoom;

  logic              s2_ready;
  mthi_pkg::result_t calc_result;

  // The result stage can load when empty or when its item leaves now.
  assign s2_ready = !out_valid || out_ready;
  // The input stage can load when empty or when its item moves on now.
  assign in_ready = !s1_valid || s2_ready;

  mthi_index_calc u_calc (
    .coord_x    (s1_x),
    .coord_y    (s1_y),
    .zoom_level (s1_zoom),
    .result     (calc_result)
  );

  // Input register: capture on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_x    <= coord_x;
      s1_y    <= coord_y;
      s1_zoom <= zoom_level;
    end
  end

  // Result register: advance when the receiver has room, hold on stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      blockset_index <= calc_result.blockset_index;
      block_index    <= calc_result.block_index;
      parcel_index   <= calc_result.parcel_index;
      unit_index     <= calc_result.unit_index;
      range_error    <= calc_result.range_error;
    end
  end

  // An error result carries only zero indices.
  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |->
      blockset_index == '0 && block_index == '0 && parcel_index == '0 && unit_index == '0)
    else $error("range_error result with nonzero index");

  // A held input item keeps its level while the result side is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(s1_zoom) && $stable(s1_x))
    else $error("input stage lost its item during a stall");

  // An empty input stage always takes an item.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input refused while input stage empty");

endmodule
